### rtl/core/awt_pkg.sv
// awt_pkg: shared types and constants of the ascii word tokenizer
// no dependencies; imported by the interfaces and all core modules

package awt_pkg;

    localparam int MAX_WORD = 64;
    localparam int ADDR_W   = $clog2(MAX_WORD);
    localparam int CNT_W    = $clog2(MAX_WORD + 1);
    localparam int LEN_W    = 7;
    localparam int CH_W     = 7;
    localparam int WORD_W   = 32;
    localparam int TAG_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_APO = 2'd2;

    localparam logic [CH_W-1:0] CH_APOSTROPHE = 7'h27;
    localparam logic [CH_W-1:0] CH_UPPER_A    = 7'h41;
    localparam logic [CH_W-1:0] CH_UPPER_Z    = 7'h5a;
    localparam logic [CH_W-1:0] CH_LOWER_A    = 7'h61;
    localparam logic [CH_W-1:0] CH_LOWER_Z    = 7'h7a;
    localparam logic [CH_W-1:0] CH_DIGIT_0    = 7'h30;
    localparam logic [CH_W-1:0] CH_DIGIT_9    = 7'h39;
    localparam logic [CH_W-1:0] CASE_DELTA    = 7'h20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } awt_state_t;

    typedef struct packed {
        logic accept;
        logic rd;
        logic advance;
    } awt_cmd_t;

    typedef struct packed {
        logic emit;
        logic last_char;
    } awt_stat_t;

endpackage

### rtl/core/awt_if.sv
// awt_in_if / awt_out_if: valid-ready channels for bytes and word characters
// depends on awt_pkg

interface awt_in_if
    import awt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   ch;
    logic              first_byte;
    logic              last_byte;
    logic [WORD_W-1:0] base_offset;
    logic [WORD_W-1:0] base_position;
    logic [TAG_W-1:0]  meta_tag;
    logic [TAG_W-1:0]  context_tag;

    modport source (
        output valid, ch, first_byte, last_byte, base_offset, base_position,
               meta_tag, context_tag,
        input  ready
    );
    modport sink (
        input  valid, ch, first_byte, last_byte, base_offset, base_position,
               meta_tag, context_tag,
        output ready
    );
endinterface

interface awt_out_if
    import awt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   word_char;
    logic              end_of_word;
    logic [LEN_W-1:0]  word_length;
    logic [WORD_W-1:0] position;
    logic [WORD_W-1:0] head_offset;
    logic [WORD_W-1:0] tail_offset;
    logic [TAG_W-1:0]  out_meta_tag;
    logic [TAG_W-1:0]  out_context_tag;

    modport source (
        output valid, word_char, end_of_word, word_length, position,
               head_offset, tail_offset, out_meta_tag, out_context_tag,
        input  ready
    );
    modport sink (
        input  valid, word_char, end_of_word, word_length, position,
               head_offset, tail_offset, out_meta_tag, out_context_tag,
        output ready
    );
endinterface

### rtl/core/ascii_word_tokenizer.sv
// ascii_word_tokenizer: top level joining controller and datapath
// depends on awt_pkg, awt_in_if, awt_out_if, awt_ctrl, awt_datapath
//
//   channel  direction  carries
//   din      sink       one ascii byte with string marks, bases and tags
//   dout     source     one lower-case character of an emitted word
//   cfg      write      min length, max length, apostrophe enable
//
// a byte that emits nothing leaves the state machine idle; accepting stops while a word goes out
// each character of an emitted word passes a store read in ST_READ, then the output
// register in ST_SEND, where output stalls can hold it
// a stalled output holds its register and the state machine waits in place
// reset clears control, tokenizer state and config; the word store needs no clearing

module ascii_word_tokenizer
    import awt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    awt_in_if.sink                din,
    awt_out_if.source             dout,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    awt_cmd_t  cmd;
    awt_stat_t stat;

    awt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_ready  (din.ready),
        .out_valid (dout.valid),
        .out_ready (dout.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    awt_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .ch              (din.ch),
        .first_byte      (din.first_byte),
        .last_byte       (din.last_byte),
        .base_offset     (din.base_offset),
        .base_position   (din.base_position),
        .meta_tag        (din.meta_tag),
        .context_tag     (din.context_tag),
        .cmd             (cmd),
        .stat            (stat),
        .word_char       (dout.word_char),
        .end_of_word     (dout.end_of_word),
        .word_length     (dout.word_length),
        .position        (dout.position),
        .head_offset     (dout.head_offset),
        .tail_offset     (dout.tail_offset),
        .out_meta_tag    (dout.out_meta_tag),
        .out_context_tag (dout.out_context_tag)
    );

endmodule

### rtl/core/awt_ctrl.sv
// awt_ctrl: state machine sequencing byte intake and word character output
// depends on awt_pkg

module awt_ctrl
    import awt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  awt_stat_t stat,
    output awt_cmd_t  cmd
);

    awt_state_t state_reg;
    awt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.emit)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.advance = 1'b1;
                    state_next  = stat.last_char ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/awt_datapath.sv
// awt_datapath: config registers, byte classification, word store and output fields
// depends on awt_pkg

module awt_datapath
    import awt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [CH_W-1:0]       ch,
    input  logic                  first_byte,
    input  logic                  last_byte,
    input  logic [WORD_W-1:0]     base_offset,
    input  logic [WORD_W-1:0]     base_position,
    input  logic [TAG_W-1:0]      meta_tag,
    input  logic [TAG_W-1:0]      context_tag,
    input  awt_cmd_t              cmd,
    output awt_stat_t             stat,
    output logic [CH_W-1:0]       word_char,
    output logic                  end_of_word,
    output logic [LEN_W-1:0]      word_length,
    output logic [WORD_W-1:0]     position,
    output logic [WORD_W-1:0]     head_offset,
    output logic [WORD_W-1:0]     tail_offset,
    output logic [TAG_W-1:0]      out_meta_tag,
    output logic [TAG_W-1:0]      out_context_tag
);

    logic [CH_W-1:0]   word_store [MAX_WORD];

    logic [LEN_W-1:0]  min_len_reg;
    logic [LEN_W-1:0]  max_len_reg;
    logic              allow_apo_reg;

    logic              inside_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              seen_reg;
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  hi_reg;
    logic [WORD_W-1:0] abs_reg;
    logic [WORD_W-1:0] pos_reg;
    logic [TAG_W-1:0]  meta_reg;
    logic [TAG_W-1:0]  context_reg;

    logic [ADDR_W-1:0] addr_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [WORD_W-1:0] end_reg;
    logic [WORD_W-1:0] start_reg;
    logic [CH_W-1:0]   rd_data_reg;

    logic              fresh;
    logic              inside_eff;
    logic [CNT_W-1:0]  count_eff;
    logic              seen_eff;
    logic [CNT_W-1:0]  lo_eff;
    logic [CNT_W-1:0]  hi_eff;
    logic [CNT_W-1:0]  count_new;
    logic              seen_new;
    logic [CNT_W-1:0]  lo_new;
    logic [CNT_W-1:0]  hi_new;
    logic              seen_sel;
    logic [CNT_W-1:0]  lo_sel;
    logic [CNT_W-1:0]  hi_sel;
    logic [CH_W-1:0]   lc;
    logic              is_alnum;
    logic              wordch;
    logic [LEN_W-1:0]  maxl;
    logic [LEN_W-1:0]  minl;
    logic              close;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] prev_abs;
    logic [WORD_W-1:0] cur_abs;
    logic [WORD_W-1:0] end_off;
    logic [WORD_W-1:0] pos_base;

    // byte classification and word bookkeeping
    always_comb
    begin
        fresh      = first_byte | ~inside_reg;
        inside_eff = ~first_byte & inside_reg;
        count_eff  = fresh ? '0 : count_reg;
        seen_eff   = fresh ? 1'b0 : seen_reg;
        lo_eff     = fresh ? '0 : lo_reg;
        hi_eff     = fresh ? '0 : hi_reg;

        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
        begin
            lc = ch + CASE_DELTA;
        end
        else
        begin
            lc = ch;
        end
        is_alnum = (lc >= CH_DIGIT_0 && lc <= CH_DIGIT_9)
                 || (lc >= CH_LOWER_A && lc <= CH_LOWER_Z);
        wordch   = is_alnum | (allow_apo_reg & (lc == CH_APOSTROPHE));

        if (max_len_reg == '0)
        begin
            maxl = LEN_W'(1);
        end
        else if (max_len_reg > LEN_W'(MAX_WORD))
        begin
            maxl = LEN_W'(MAX_WORD);
        end
        else
        begin
            maxl = max_len_reg;
        end
        minl = (min_len_reg == '0) ? LEN_W'(1) : min_len_reg;

        count_new = count_eff + CNT_W'(1);
        seen_new  = seen_eff | is_alnum;
        lo_new    = (is_alnum & ~seen_eff) ? count_eff : lo_eff;
        hi_new    = is_alnum ? count_new : hi_eff;

        seen_sel = wordch ? seen_new : seen_eff;
        lo_sel   = wordch ? lo_new : lo_eff;
        hi_sel   = wordch ? hi_new : hi_eff;

        if (wordch)
        begin
            close = (LEN_W'(count_new) >= maxl) | last_byte;
        end
        else
        begin
            close = inside_eff;
        end
        len = seen_sel ? LEN_W'(hi_sel - lo_sel) : '0;

        prev_abs = first_byte ? base_offset : abs_reg;
        cur_abs  = prev_abs + WORD_W'(1);
        end_off  = wordch ? cur_abs : prev_abs;
        pos_base = first_byte ? base_position : pos_reg;

        stat.emit      = close & (len >= minl);
        stat.last_char = (rem_reg == LEN_W'(1));
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg   <= LEN_W'(1);
            max_len_reg   <= LEN_W'(MAX_WORD);
            allow_apo_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_LEN:   min_len_reg   <= cfg_data;
                CFG_MAX_LEN:   max_len_reg   <= cfg_data;
                CFG_ALLOW_APO: allow_apo_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // tokenizer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg  <= 1'b0;
            count_reg   <= '0;
            seen_reg    <= 1'b0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            abs_reg     <= '0;
            pos_reg     <= '0;
            meta_reg    <= '0;
            context_reg <= '0;
        end
        else if (cmd.accept)
        begin
            inside_reg <= wordch & ~close;
            count_reg  <= (wordch & ~close) ? count_new : '0;
            seen_reg   <= seen_sel;
            lo_reg     <= lo_sel;
            hi_reg     <= hi_sel;
            abs_reg    <= cur_abs;
            pos_reg    <= pos_base + WORD_W'(stat.emit);
            if (first_byte)
            begin
                meta_reg    <= meta_tag;
                context_reg <= context_tag;
            end
        end
    end

    // emission counters and offsets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (cmd.accept & stat.emit)
        begin
            rem_reg <= len;
        end
        else if (cmd.advance)
        begin
            rem_reg <= rem_reg - LEN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept & stat.emit)
        begin
            addr_reg <= lo_sel[ADDR_W-1:0];
            len_reg  <= len;
            end_reg  <= end_off;
        end
        else if (cmd.advance)
        begin
            addr_reg <= addr_reg + ADDR_W'(1);
        end
        if (cmd.rd)
        begin
            start_reg <= end_reg - WORD_W'(len_reg) + WORD_W'(1);
        end
    end

    // word store
    always_ff @(posedge clk)
    begin
        if (cmd.accept & wordch)
        begin
            word_store[count_eff[ADDR_W-1:0]] <= lc;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= word_store[addr_reg];
        end
    end

    assign word_char       = rd_data_reg;
    assign end_of_word     = stat.last_char;
    assign word_length     = len_reg;
    assign position        = pos_reg;
    assign head_offset     = start_reg;
    assign tail_offset     = end_reg;
    assign out_meta_tag    = meta_reg;
    assign out_context_tag = context_reg;

endmodule
